@@ hdl/mcrc_pkg.sv @@
// Shared types, codes and the CRC-16 byte update for the Modbus reply checker.
// No dependencies; every other file in hdl refers to this package by scoped names.
package mcrc_pkg;

   localparam int FrameLen = 9;
   localparam int CrcLen   = 7;
   localparam int CountW   = 4;

   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
   localparam logic [7:0]  DATA_BYTES      = 8'h04;
   localparam int          EXC_FLAG_BIT    = 7;

   localparam logic [CountW-1:0] FRAME_COUNT = CountW'(FrameLen);
   localparam logic [CountW-1:0] CRC_COUNT   = CountW'(CrcLen);
   localparam logic [CountW-1:0] EXC_MIN     = CountW'(3);

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_NO_REPLY = 3'd1;
   localparam logic [2:0] STATUS_PARTIAL  = 3'd2;
   localparam logic [2:0] STATUS_EXCEPT   = 3'd3;
   localparam logic [2:0] STATUS_BAD_ADDR = 3'd4;
   localparam logic [2:0] STATUS_BAD_FUNC = 3'd5;
   localparam logic [2:0] STATUS_BAD_CNT  = 3'd6;
   localparam logic [2:0] STATUS_BAD_CRC  = 3'd7;

   localparam logic [2:0] COMFORT_OK    = 3'd0;
   localparam logic [2:0] COMFORT_COLD  = 3'd1;
   localparam logic [2:0] COMFORT_HOT   = 3'd2;
   localparam logic [2:0] COMFORT_DRY   = 3'd3;
   localparam logic [2:0] COMFORT_HUMID = 3'd4;

   localparam logic [2:0] CSR_DEVICE_ADDRESS = 3'd0;
   localparam logic [2:0] CSR_TEMP_LOW       = 3'd1;
   localparam logic [2:0] CSR_TEMP_HIGH      = 3'd2;
   localparam logic [2:0] CSR_HUMID_LOW      = 3'd3;
   localparam logic [2:0] CSR_HUMID_HIGH     = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        connected;
      logic [15:0] temperature_tenths;
      logic [15:0] humidity_tenths;
      logic [2:0]  comfort;
      logic [6:0]  exception_function;
      logic [7:0]  exception_code;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  device_address;
      logic [15:0] temp_low_tenths;
      logic [15:0] temp_high_tenths;
      logic [15:0] humid_low_tenths;
      logic [15:0] humid_high_tenths;
   } cfg_type;

   typedef struct packed {
      logic [FrameLen-1:0][7:0] bytes;
      logic [CountW-1:0]        count;
      logic [15:0]              crc;
   } frame_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ hdl/mcrc_frame.sv @@
// Frame capture: first nine reply bytes, saturating byte count and running CRC-16.
// Depends on mcrc_pkg for frame_type, lengths and the CRC byte update.
module mcrc_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_we,
   input  logic [7:0]          rx_byte,
   input  logic                clear,
   output mcrc_pkg::frame_type frame
);

   logic [mcrc_pkg::FrameLen-1:0][7:0] bytes_ff, bytes_in;
   logic [mcrc_pkg::CountW-1:0]        count_ff, count_in;
   logic [15:0]                        crc_ff, crc_in;
   logic                               room;

   assign room = count_ff < mcrc_pkg::FRAME_COUNT;

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      if (clear) begin
         count_in = '0;
         crc_in   = mcrc_pkg::CRC_INIT;
      end else if (byte_we && room) begin
         for (int i = 0; i < mcrc_pkg::FrameLen; i++) begin
            if (count_ff == mcrc_pkg::CountW'(i)) begin
               bytes_in[i] = rx_byte;
            end
         end
         if (count_ff < mcrc_pkg::CRC_COUNT) begin
            crc_in = mcrc_pkg::crc_update(crc_ff, rx_byte);
         end
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= mcrc_pkg::CRC_INIT;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   assign frame = {bytes_ff, count_ff, crc_ff};

endmodule

@@ hdl/mcrc_classify.sv @@
// Reply classification at window end: status, readings, comfort class, exception fields.
// Depends on mcrc_pkg for frame_type, cfg_type, rsp_type and the status and comfort codes.
module mcrc_classify (
   input  mcrc_pkg::frame_type frame,
   input  mcrc_pkg::cfg_type   cfg,
   input  logic [15:0]         held_temperature,
   input  logic [15:0]         held_humidity,
   output mcrc_pkg::rsp_type   result,
   output logic                good
);

   logic [15:0] temp;
   logic [15:0] humid;
   logic [15:0] rx_crc;
   logic [2:0]  status;
   logic [2:0]  comfort;

   assign temp   = {frame.bytes[3], frame.bytes[4]};
   assign humid  = {frame.bytes[5], frame.bytes[6]};
   assign rx_crc = {frame.bytes[8], frame.bytes[7]};

   always_comb begin
      if (frame.count == '0) begin
         status = mcrc_pkg::STATUS_NO_REPLY;
      end else if (frame.count < mcrc_pkg::FRAME_COUNT) begin
         if (frame.count >= mcrc_pkg::EXC_MIN && frame.bytes[1][mcrc_pkg::EXC_FLAG_BIT]) begin
            status = mcrc_pkg::STATUS_EXCEPT;
         end else begin
            status = mcrc_pkg::STATUS_PARTIAL;
         end
      end else if (frame.bytes[0] != cfg.device_address) begin
         status = mcrc_pkg::STATUS_BAD_ADDR;
      end else if (frame.bytes[1] != mcrc_pkg::FUNC_READ_INPUT) begin
         status = mcrc_pkg::STATUS_BAD_FUNC;
      end else if (frame.bytes[2] != mcrc_pkg::DATA_BYTES) begin
         status = mcrc_pkg::STATUS_BAD_CNT;
      end else if (rx_crc != frame.crc) begin
         status = mcrc_pkg::STATUS_BAD_CRC;
      end else begin
         status = mcrc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      if (temp < cfg.temp_low_tenths) begin
         comfort = mcrc_pkg::COMFORT_COLD;
      end else if (temp > cfg.temp_high_tenths) begin
         comfort = mcrc_pkg::COMFORT_HOT;
      end else if (humid < cfg.humid_low_tenths) begin
         comfort = mcrc_pkg::COMFORT_DRY;
      end else if (humid > cfg.humid_high_tenths) begin
         comfort = mcrc_pkg::COMFORT_HUMID;
      end else begin
         comfort = mcrc_pkg::COMFORT_OK;
      end
   end

   assign good = status == mcrc_pkg::STATUS_OK;

   always_comb begin
      result.status             = status;
      result.connected          = good;
      result.temperature_tenths = good ? temp : held_temperature;
      result.humidity_tenths    = good ? humid : held_humidity;
      result.comfort            = good ? comfort : mcrc_pkg::COMFORT_OK;
      result.exception_function = '0;
      result.exception_code     = '0;
      if (status == mcrc_pkg::STATUS_EXCEPT) begin
         result.exception_function = frame.bytes[1][6:0];
         result.exception_code     = frame.bytes[2];
      end
   end

endmodule

@@ hdl/modbus_climate_response_checker.sv @@
// Top level of the Modbus RTU read-input-registers reply checker.
// Depends on mcrc_pkg, mcrc_frame and mcrc_classify.
//
//   port group   direction  payload       transfer
//   req_*        in         req_type      one byte or one window-end event
//   rsp_*        out        rsp_type      one result per window-end event
//   csr_*        in         index, data   one register write, always ready
//
// A request is taken every cycle while the result register is empty or being drained.
// A byte updates the frame store, count and CRC at the edge it is accepted; a window
// end is classified from those registers and lands in the result register at that edge.
// rsp_valid rises in the cycle after the window end is accepted; a stalled rsp_ready holds requests.
// Reset clears counts, held readings and the result valid bit, sets the CRC to its initial
// value and loads register defaults.
module modbus_climate_response_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mcrc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcrc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);

   mcrc_pkg::cfg_type   cfg_ff;
   mcrc_pkg::frame_type frame;
   mcrc_pkg::rsp_type   result;
   mcrc_pkg::rsp_type   rsp_data_ff;
   logic                rsp_valid_ff;
   logic [15:0]         held_temp_ff;
   logic [15:0]         held_humid_ff;
   logic                good;
   logic                req_take;
   logic                byte_take;
   logic                end_take;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign byte_take = req_take && req_data.kind == mcrc_pkg::KIND_BYTE;
   assign end_take  = req_take && req_data.kind == mcrc_pkg::KIND_END;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= 8'd1;
         cfg_ff.temp_low_tenths   <= 16'd200;
         cfg_ff.temp_high_tenths  <= 16'd260;
         cfg_ff.humid_low_tenths  <= 16'd400;
         cfg_ff.humid_high_tenths <= 16'd600;
      end else if (csr_valid) begin
         unique case (csr_index)
            mcrc_pkg::CSR_DEVICE_ADDRESS: cfg_ff.device_address    <= csr_data[7:0];
            mcrc_pkg::CSR_TEMP_LOW:       cfg_ff.temp_low_tenths   <= csr_data;
            mcrc_pkg::CSR_TEMP_HIGH:      cfg_ff.temp_high_tenths  <= csr_data;
            mcrc_pkg::CSR_HUMID_LOW:      cfg_ff.humid_low_tenths  <= csr_data;
            mcrc_pkg::CSR_HUMID_HIGH:     cfg_ff.humid_high_tenths <= csr_data;
            default: ;
         endcase
      end
   end

   mcrc_frame u_frame (
      .clock   (clock),
      .reset   (reset),
      .byte_we (byte_take),
      .rx_byte (req_data.rx_byte),
      .clear   (end_take),
      .frame   (frame)
   );

   mcrc_classify u_classify (
      .frame            (frame),
      .cfg              (cfg_ff),
      .held_temperature (held_temp_ff),
      .held_humidity    (held_humid_ff),
      .result           (result),
      .good             (good)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_temp_ff  <= '0;
         held_humid_ff <= '0;
      end else if (end_take && good) begin
         held_temp_ff  <= result.temperature_tenths;
         held_humid_ff <= result.humidity_tenths;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (end_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (end_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
